// ----- rtl/core/aafp_pkg.sv -----
`default_nettype none
package aafp_pkg;

    // Datapath width of both CORDIC engines
    localparam int W = 62;
    localparam int GUARD_SHIFT = 24;
    localparam int TABLE_LEN = 24;
    localparam logic signed [25:0] GAIN_Q24 = 26'sd27628053;
    localparam logic signed [27:0] FULL_TURN_Q16 = 28'sd23592960;
    localparam logic signed [27:0] HALF_TURN_Q16 = 28'sd11796480;

    typedef longint t_atan_tab [0:TABLE_LEN-1];

    // atan(2^-i) in degrees, Q24
    localparam t_atan_tab ATAN_DEG_Q24 = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // Table angle rounded half up to frac fraction bits
    function automatic longint table_angle(input int i, input int frac);
        int sh;
        sh = 24 - frac;
        return (ATAN_DEG_Q24[i] + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/aim_angle_from_points.sv -----
`default_nettype none
// Aim correction: takes a start point, an end point (Q16.16) and the current view pitch and
// yaw (degrees Q9.16), and returns the pitch and yaw corrections toward the direction
// end - start, each wrapped to [-180, 180] degrees in Q8.16. Yaw is atan2(dy, dx) and pitch
// atan2(-dz, hypot(dx, dy)), from two vectoring CORDIC engines in series, one register
// stage per CORDIC iteration. One request is accepted every cycle unless the output stalls.
// A zero direction gives angle 0.
module aim_angle_from_points #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_start_x,
    input  wire signed [31:0]  i_start_y,
    input  wire signed [31:0]  i_start_z,
    input  wire signed [31:0]  i_end_x,
    input  wire signed [31:0]  i_end_y,
    input  wire signed [31:0]  i_end_z,
    input  wire signed [25:0]  i_view_pitch,
    input  wire signed [25:0]  i_view_yaw,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [24:0] o_pitch_delta,
    output logic signed [24:0] o_yaw_delta
);

    localparam int W   = aafp_pkg::W;
    localparam int N   = (CORDIC_STAGES < aafp_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : aafp_pkg::TABLE_LEN;
    localparam int ZW  = FRAC_BITS + 10;
    localparam int L   = 2 * N + 5;
    localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam longint RND = (UP > 0) ? (64'sd1 <<< (UP - 1)) : 64'sd0;
    localparam logic signed [ZW-1:0] HALF_Z = ZW'(longint'(180) <<< FRAC_BITS);

    logic adv;
    logic [L-1:0] r_v;

    assign adv     = !r_v[L-1] || i_ready;
    assign o_ready = i_rst_n && adv;
    assign o_valid = r_v[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[L-2:0], i_valid};
        end
    end

    // Stage A: direction
    logic signed [33:0] r_a_dx, r_a_dy, r_a_dz;
    logic signed [25:0] r_a_vp, r_a_vy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_dx <= 34'(i_end_x) - 34'(i_start_x);
            r_a_dy <= 34'(i_end_y) - 34'(i_start_y);
            r_a_dz <= 34'(i_end_z) - 34'(i_start_z);
            r_a_vp <= i_view_pitch;
            r_a_vy <= i_view_yaw;
        end
    end

    // Stage B: yaw CORDIC setup, scaled -dz
    logic signed [W-1:0]  r_yx [0:N];
    logic signed [W-1:0]  r_yy [0:N];
    logic signed [ZW-1:0] r_yz [0:N];
    logic                 r_yzero [0:N];
    logic signed [W-1:0]  r_ypy [0:N];
    logic signed [25:0]   r_yvp [0:N];
    logic signed [25:0]   r_yvy [0:N];

    logic signed [W-1:0] b_x, b_y;
    logic signed [59:0]  b_prod;

    always_comb begin
        b_x    = W'(r_a_dx) <<< aafp_pkg::GUARD_SHIFT;
        b_y    = W'(r_a_dy) <<< aafp_pkg::GUARD_SHIFT;
        b_prod = 60'(-r_a_dz) * 60'(aafp_pkg::GAIN_Q24);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_yzero[0] <= (r_a_dx == '0) && (r_a_dy == '0);
            if (b_x[W-1]) begin
                r_yx[0] <= -b_x;
                r_yy[0] <= -b_y;
                r_yz[0] <= b_y[W-1] ? -HALF_Z : HALF_Z;
            end else begin
                r_yx[0] <= b_x;
                r_yy[0] <= b_y;
                r_yz[0] <= '0;
            end
            r_ypy[0] <= W'(b_prod);
            r_yvp[0] <= r_a_vp;
            r_yvy[0] <= r_a_vy;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_yaw
            localparam logic signed [ZW-1:0] ANG = ZW'(aafp_pkg::table_angle(gi, FRAC_BITS));
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (!r_yy[gi][W-1]) begin
                        r_yx[gi+1] <= r_yx[gi] + (r_yy[gi] >>> gi);
                        r_yy[gi+1] <= r_yy[gi] - (r_yx[gi] >>> gi);
                        r_yz[gi+1] <= r_yz[gi] + ANG;
                    end else begin
                        r_yx[gi+1] <= r_yx[gi] - (r_yy[gi] >>> gi);
                        r_yy[gi+1] <= r_yy[gi] + (r_yx[gi] >>> gi);
                        r_yz[gi+1] <= r_yz[gi] - ANG;
                    end
                    r_yzero[gi+1] <= r_yzero[gi];
                    r_ypy[gi+1]   <= r_ypy[gi];
                    r_yvp[gi+1]   <= r_yvp[gi];
                    r_yvy[gi+1]   <= r_yvy[gi];
                end
            end
        end
    endgenerate

    // Pitch CORDIC setup on (hypot, -dz), carry the finished yaw
    logic signed [W-1:0]  r_px [0:N];
    logic signed [W-1:0]  r_py [0:N];
    logic signed [ZW-1:0] r_pz [0:N];
    logic                 r_pzero [0:N];
    logic signed [ZW-1:0] r_pyaw [0:N];
    logic signed [25:0]   r_pvp [0:N];
    logic signed [25:0]   r_pvy [0:N];

    logic signed [W-1:0] c_x;
    assign c_x = r_yzero[N] ? '0 : r_yx[N];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pzero[0] <= (c_x == '0) && (r_ypy[N] == '0);
            if (c_x[W-1]) begin
                r_px[0] <= -c_x;
                r_py[0] <= -r_ypy[N];
                r_pz[0] <= r_ypy[N][W-1] ? -HALF_Z : HALF_Z;
            end else begin
                r_px[0] <= c_x;
                r_py[0] <= r_ypy[N];
                r_pz[0] <= '0;
            end
            r_pyaw[0] <= r_yzero[N] ? '0 : r_yz[N];
            r_pvp[0]  <= r_yvp[N];
            r_pvy[0]  <= r_yvy[N];
        end
    end

    generate
        for (gi = 0; gi < N; gi++) begin : g_pitch
            localparam logic signed [ZW-1:0] ANG = ZW'(aafp_pkg::table_angle(gi, FRAC_BITS));
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (!r_py[gi][W-1]) begin
                        r_px[gi+1] <= r_px[gi] + (r_py[gi] >>> gi);
                        r_py[gi+1] <= r_py[gi] - (r_px[gi] >>> gi);
                        r_pz[gi+1] <= r_pz[gi] + ANG;
                    end else begin
                        r_px[gi+1] <= r_px[gi] - (r_py[gi] >>> gi);
                        r_py[gi+1] <= r_py[gi] + (r_px[gi] >>> gi);
                        r_pz[gi+1] <= r_pz[gi] - ANG;
                    end
                    r_pzero[gi+1] <= r_pzero[gi];
                    r_pyaw[gi+1]  <= r_pyaw[gi];
                    r_pvp[gi+1]   <= r_pvp[gi];
                    r_pvy[gi+1]   <= r_pvy[gi];
                end
            end
        end
    endgenerate

    // Round to Q16 and subtract the view angles
    logic signed [27:0] r_dp, r_dy;
    logic signed [ZW+1:0] d_pz, d_yz;
    logic signed [27:0] d_pq, d_yq;

    always_comb begin
        d_pz = r_pzero[N] ? '0 : (ZW+2)'(r_pz[N]);
        d_yz = (ZW+2)'(r_pyaw[N]);
        d_pq = 28'((d_pz + (ZW+2)'(RND)) >>> UP) <<< DN;
        d_yq = 28'((d_yz + (ZW+2)'(RND)) >>> UP) <<< DN;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dp <= d_pq - 28'(r_pvp[N]);
            r_dy <= d_yq - 28'(r_pvy[N]);
        end
    end

    // Wrap to [-180, 180], ties to the even quotient
    function automatic logic signed [24:0] wrap360(input logic signed [27:0] d);
        logic signed [27:0] r, c;
        logic               odd;
        r   = d;
        odd = 1'b0;
        for (int k = -3; k <= 3; k++) begin
            c = d - 28'(k) * aafp_pkg::FULL_TURN_Q16;
            if (!c[27] && c < aafp_pkg::FULL_TURN_Q16) begin
                r   = c;
                odd = k[0];
            end
        end
        if (r > aafp_pkg::HALF_TURN_Q16 || (r == aafp_pkg::HALF_TURN_Q16 && odd)) begin
            r = r - aafp_pkg::FULL_TURN_Q16;
        end
        return r[24:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_pitch_delta <= wrap360(r_dp);
            o_yaw_delta   <= wrap360(r_dy);
        end
    end

endmodule
`default_nettype wire
